FILE: rtl/core/psbh_pkg.sv
// ----------------------------------------------------------------------------
// psbh_pkg: shared types and constants of the polynomial string bucket hash
// Widths of the hash, bucket and byte fields and the record that moves
// through the chain of remainder cells.
// ----------------------------------------------------------------------------
package psbh_pkg;

  localparam int unsigned SUM_W    = 32;  // running sum, also number of cells
  localparam int unsigned BUCKET_W = 31;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [SUM_W-1:0]    HASH_BASE    = 32'd37;
  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 31'd200000;

  // One slot of the remainder chain.
  typedef struct packed {
    logic                valid;
    logic [BUCKET_W-1:0] rem;  // partial remainder
    logic [SUM_W-1:0]    dvd;  // dividend bits not yet consumed, MSB first
  } stage_t;

endpackage

FILE: rtl/core/psbh_accum.sv
// ----------------------------------------------------------------------------
// psbh_accum: running base-37 sum of the incoming string bytes
// Loads the sum on a string's first byte, folds later bytes in, and hands
// the finished sum to the remainder chain on the last byte.
// ----------------------------------------------------------------------------
module psbh_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [psbh_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         last,
  output logic                         at_start,
  output psbh_pkg::stage_t             head
);
  import psbh_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] byte_ext;

  assign byte_ext = {{(SUM_W-BYTE_W){1'b0}}, data_byte};
  // sum*37 wraps modulo 2^32
  assign sum_next = at_start ? byte_ext : (sum * HASH_BASE) + byte_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      at_start <= 1'b1;
    end else if (accept) begin
      sum      <= sum_next;
      at_start <= last;
    end
  end

  always_comb begin
    head.valid = accept && last;
    head.rem   = '0;
    head.dvd   = sum_next;
  end

endmodule

FILE: rtl/core/psbh_cell.sv
// ----------------------------------------------------------------------------
// psbh_cell: one restoring remainder step
// Shifts one dividend bit into the partial remainder, subtracts the bucket
// count when it fits, and registers the slot for the next cell.
// ----------------------------------------------------------------------------
module psbh_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [psbh_pkg::BUCKET_W-1:0] divisor,
  input  psbh_pkg::stage_t              din,
  output psbh_pkg::stage_t              dout
);
  import psbh_pkg::*;

  logic [BUCKET_W:0] trial;
  logic [BUCKET_W:0] divisor_ext;
  logic [BUCKET_W:0] diff;
  logic              fits;
  stage_t            step;

  assign trial       = {din.rem, din.dvd[SUM_W-1]};
  assign divisor_ext = {1'b0, divisor};
  assign fits        = trial >= divisor_ext;
  assign diff        = trial - divisor_ext;

  // trial < 2*divisor, so either branch fits in BUCKET_W bits
  always_comb begin
    step.valid = din.valid;
    step.rem   = fits ? diff[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
    step.dvd   = {din.dvd[SUM_W-2:0], 1'b0};
  end

  // only the valid bit is reset; data follows it
  always_ff @(posedge clk) begin
    if (advance) begin
      dout.rem <= step.rem;
      dout.dvd <= step.dvd;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= step.valid;
    end
  end

endmodule

FILE: rtl/core/polynomial_string_bucket_hash.sv
// ----------------------------------------------------------------------------
// polynomial_string_bucket_hash: base-37 string hash reduced to a bucket
// Byte stream in, one bucket index per string out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one string byte per request; s_tlast marks the final byte.
//   The first byte of a string loads the 32-bit sum, later bytes give
//   sum*37 + byte (mod 2^32). On the last byte the sum enters a chain of 32
//   remainder cells, one dividend bit per cell, and m_* delivers
//   sum mod bucket_count. A bucket_count of zero yields bucket 0.
//   Throughput: one byte per cycle while m_* is not stalled; bytes of following
//   strings stream in while earlier sums move down the chain. The bucket shows
//   on m_* once the sum has passed all 32 remainder cells; the last cell is
//   the output register.
//   Stall: while a result waits on m_* and m_tready is low, the whole chain
//   and the input hold (s_tready low); nothing is dropped.
//   Reset: rst clears the chain, arms the start-of-string flag and sets
//   bucket_count to 200000. cfg_wen writes bucket_count; write it only with
//   no string in flight.
// ----------------------------------------------------------------------------
module polynomial_string_bucket_hash (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wen,
  input  logic [psbh_pkg::BUCKET_W-1:0] cfg_wdata,  // bucket_count
  // byte stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,    // [7:0] data_byte
  input  logic                          s_tlast,    // last byte of string
  // bucket results out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata     // [30:0] bucket, [31] zero
);
  import psbh_pkg::*;

  logic [BUCKET_W-1:0] bucket_count;
  logic [BUCKET_W-1:0] bucket;
  logic                advance;
  logic                accept;
  logic                at_start;
  stage_t              chain [SUM_W+1];  // chain[0] is the head, chain[i+1] cell i

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_RESET;
    end else if (cfg_wen) begin
      bucket_count <= cfg_wdata;
    end
  end

  // The last cell doubles as the output register; everything moves together.
  assign advance  = !chain[SUM_W].valid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  psbh_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata[BYTE_W-1:0]),
    .last      (s_tlast),
    .at_start  (at_start),
    .head      (chain[0])
  );

  for (genvar i = 0; i < SUM_W; i++) begin : g_cell
    psbh_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .divisor (bucket_count),
      .din     (chain[i]),
      .dout    (chain[i+1])
    );
  end

  // zero buckets: the chain just shifts the sum through, so force bucket 0;
  // the user must keep bucket_count steady while a sum is in the chain; not enforced here
  assign bucket   = (bucket_count == '0) ? {BUCKET_W{1'b0}} : chain[SUM_W].rem;
  assign m_tvalid = chain[SUM_W].valid;
  assign m_tdata  = {1'b0, bucket};

  // a last byte always lands in the first cell
  a_last_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> g_cell[0].u_cell.dout.valid)
    else $error("last byte did not enter the remainder chain");

  // a byte that is not last leaves the block mid-string
  a_mid_string: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tlast) |=> !at_start)
    else $error("start flag set after a byte that is not last");

  // a stalled chain holds its slots
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    (!advance) |=> ($stable(g_cell[0].u_cell.dout.valid) && $stable(m_tvalid)))
    else $error("remainder chain moved while stalled");

endmodule
